### rtl/camera_line_follow_pd_steering_unit_assert.svh
// Assertion macros shared by the steering unit RTL.
`ifndef CAMERA_LINE_FOLLOW_PD_STEERING_UNIT_ASSERT_SVH
`define CAMERA_LINE_FOLLOW_PD_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CLPD_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("clpd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CLPD_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("clpd: next-cycle check failed");

`endif

### rtl/clpd_pkg.sv
// Shared types and constants of the line-follow PD steering unit.
`default_nettype none

package clpd_pkg;

	localparam int ROW_WIDTH_DEF     = 320;
	localparam int COLUMN_HEIGHT_DEF = 240;

	localparam int PIX_W       = 8;
	localparam int POS_W       = 9;
	localparam int ERR_W       = 15;
	localparam int ROWCNT_W    = 9;
	localparam int HALFCNT_W   = 8;
	localparam int DRIVE_W     = 9;
	localparam int HOLD_W      = 18;
	localparam int ACT_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;
	localparam int QUEUE_DEPTH = 2;

	// Stream payload widths, padded to whole bytes.
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 40;

	typedef enum logic [ACT_W-1:0] {
		ACT_STEER    = 3'd0,
		ACT_STRAIGHT = 3'd1,
		ACT_REVERSE  = 3'd2,
		ACT_SPIN     = 3'd3,
		ACT_MODE     = 3'd4
	} action_t;

	typedef struct packed {
		logic [7:0] pixel_threshold;
		logic [9:0] prop_gain_q8;
		logic [9:0] deriv_gain_q8;
		logic [7:0] base_speed;
		logic [7:0] scale_divisor;
		logic [8:0] exit_white_count;
		logic [8:0] min_white_count;
		logic [7:0] cross_count;
	} cfg_t;

	// Summary of one frame, handed from the pixel front to the control back.
	typedef struct packed {
		logic signed [ERR_W-1:0] error_accum;
		logic [ROWCNT_W-1:0]     row_white;
		logic [HALFCNT_W-1:0]    column_white;
		logic [HALFCNT_W-1:0]    upper_half_white;
		logic [1:0]              edge_white_flags;
	} frame_rec_t;

	// Queue handshake toward the back end.
	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} rec_req_t;

endpackage

`default_nettype wire

### rtl/clpd_front.sv
// Pixel front end: threshold, accumulate frame statistics, emit a frame summary.
`default_nettype none

module clpd_front import clpd_pkg::*; #(
	parameter int ROW_WIDTH     = ROW_WIDTH_DEF,
	parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [PIX_W-1:0] pixel_value,
	input  wire logic [POS_W-1:0] pixel_pos,
	input  wire logic             is_column,
	input  wire logic             end_of_frame,
	input  wire logic [7:0]       pixel_threshold,
	input  wire logic             q_full,
	output rec_req_t              push
);

	localparam int CMP_W = 11;
	localparam int DEL_W = 12;
	localparam int SUM_W = ERR_W + 2;
	localparam logic [CMP_W-1:0] ROW_LIM  = CMP_W'(ROW_WIDTH);
	localparam logic [CMP_W-1:0] COL_LIM  = CMP_W'(COLUMN_HEIGHT);
	localparam logic [CMP_W-1:0] ROW_MID  = CMP_W'(ROW_WIDTH / 2);
	localparam logic [CMP_W-1:0] ROW_LAST = CMP_W'(ROW_WIDTH - 1);
	localparam logic signed [SUM_W-1:0] ERR_HI = SUM_W'(16383);
	localparam logic signed [SUM_W-1:0] ERR_LO = -SUM_W'(16384);

	logic signed [ERR_W-1:0] err_q;
	logic [ROWCNT_W-1:0]     row_q;
	logic [HALFCNT_W-1:0]    col_q;
	logic [HALFCNT_W-1:0]    up_q;
	logic [1:0]              edge_q;

	logic                    accept;
	logic                    white;
	logic [CMP_W-1:0]        pos_ext;
	logic                    row_hit;
	logic                    col_hit;
	logic signed [DEL_W-1:0] delta;
	logic signed [SUM_W-1:0] acc_sum;
	frame_rec_t              nxt;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		white   = pixel_value >= pixel_threshold;
		pos_ext = CMP_W'(pixel_pos);
		row_hit = !is_column && (pos_ext < ROW_LIM);
		col_hit = is_column && (pos_ext < COL_LIM);
		delta   = $signed({3'b000, pixel_pos}) - $signed({1'b0, ROW_MID});
		acc_sum = SUM_W'(err_q) + SUM_W'(delta);

		nxt.error_accum      = err_q;
		nxt.row_white        = row_q;
		nxt.column_white     = col_q;
		nxt.upper_half_white = up_q;
		nxt.edge_white_flags = edge_q;

		if (col_hit && white && !(&col_q)) begin
			nxt.column_white = col_q + 1'b1;
		end
		if (row_hit) begin
			if (pos_ext == '0) begin
				nxt.edge_white_flags[0] = white;
			end
			if (pos_ext == ROW_LAST) begin
				nxt.edge_white_flags[1] = white;
			end
			if (white) begin
				if (!(&row_q)) begin
					nxt.row_white = row_q + 1'b1;
				end
				if ((pos_ext >= ROW_MID) && !(&up_q)) begin
					nxt.upper_half_white = up_q + 1'b1;
				end
				// saturate the error sum to its 15-bit signed range
				if (acc_sum > ERR_HI) begin
					nxt.error_accum = ERR_HI[ERR_W-1:0];
				end else if (acc_sum < ERR_LO) begin
					nxt.error_accum = ERR_LO[ERR_W-1:0];
				end else begin
					nxt.error_accum = acc_sum[ERR_W-1:0];
				end
			end
		end
	end

	assign push.valid = accept && end_of_frame;
	assign push.rec   = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
			up_q   <= '0;
			edge_q <= '0;
		end else if (accept) begin
			edge_q <= nxt.edge_white_flags;
			if (end_of_frame) begin
				err_q <= '0;
				row_q <= '0;
				col_q <= '0;
				up_q  <= '0;
			end else begin
				err_q <= nxt.error_accum;
				row_q <= nxt.row_white;
				col_q <= nxt.column_white;
				up_q  <= nxt.upper_half_white;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/clpd_queue.sv
// Short queue of frame summaries between the front and back ends.
`default_nettype none

module clpd_queue import clpd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  rec_req_t  push,
	output logic      full,
	output rec_req_t  head,
	input  wire logic pop
);

	`include "camera_line_follow_pd_steering_unit_assert.svh"

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	frame_rec_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = cnt_q == CNT_FULL;
	assign head.valid = cnt_q != '0;
	assign head.rec   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`CLPD_ASSERT_IMP(a_q_no_overflow, push.valid, !full)
	`CLPD_ASSERT_IMP(a_q_no_underflow, pop, head.valid)
	`CLPD_ASSERT_NXT(a_q_fill_step, push.valid && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

`default_nettype wire

### rtl/clpd_back.sv
// Control back end: PD law, iterative divide, mode decision and result register.
`default_nettype none

module clpd_back import clpd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  cfg_t                       cfg,
	input  rec_req_t                   head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic signed [DRIVE_W-1:0]  left_drive,
	output logic signed [DRIVE_W-1:0]  right_drive,
	output logic [HOLD_W-1:0]          hold_us,
	output logic                       crossing_mode,
	output action_t                    action
);

	`include "camera_line_follow_pd_steering_unit_assert.svh"

	localparam int PP_W  = ERR_W + 11;
	localparam int DIF_W = ERR_W + 1;
	localparam int DP_W  = DIF_W + 11;
	localparam int PQ_W  = PP_W - 8;
	localparam int DQ_W  = DP_W - 8;
	localparam int SUM_W = DQ_W + 1;
	localparam int MAG_W = SUM_W - 1;
	localparam int CNT_W = $clog2(MAG_W + 1);
	localparam int WIDE_W = SUM_W + 1;

	localparam logic signed [DRIVE_W-1:0] DRV_LOST = -DRIVE_W'(60);
	localparam logic signed [DRIVE_W-1:0] DRV_SPIN = DRIVE_W'(70);
	localparam logic signed [DRIVE_W-1:0] DRV_BACK = -DRIVE_W'(50);
	localparam logic [HOLD_W-1:0] HOLD_LOST = HOLD_W'(200000);
	localparam logic [HOLD_W-1:0] HOLD_SPIN = HOLD_W'(250000);
	localparam logic [HOLD_W-1:0] HOLD_BACK = HOLD_W'(100000);
	localparam logic signed [WIDE_W-1:0] DRV_HI = WIDE_W'(255);
	localparam logic signed [WIDE_W-1:0] DRV_LO = -WIDE_W'(255);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_DEC
	} state_t;

	state_t                  state_q;
	logic                    mode_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic [CNT_W-1:0]        div_cnt_q;

	frame_rec_t              rec_q;
	logic signed [PP_W-1:0]  p_prod_q;
	logic signed [DP_W-1:0]  d_prod_q;
	logic                    neg_q;
	logic [MAG_W-1:0]        dvd_q;
	logic [7:0]              rem_q;

	logic signed [DIF_W-1:0]  diff;
	logic signed [PP_W-1:0]   p_mult;
	logic signed [DP_W-1:0]   d_mult;
	logic signed [PP_W-1:0]   p_adj;
	logic signed [DP_W-1:0]   d_adj;
	logic signed [SUM_W-1:0]  pd_sum;
	logic [SUM_W-1:0]         pd_mag;
	logic [7:0]               div_eff;
	logic [8:0]               trial;
	logic                     trial_ge;
	logic signed [SUM_W-1:0]  steer;
	logic signed [WIDE_W-1:0] base_w;
	logic signed [DRIVE_W-1:0] steer_left;
	logic signed [DRIVE_W-1:0] steer_right;
	logic signed [DRIVE_W-1:0] base_drv;
	logic                     load;

	action_t                   act_d;
	logic signed [DRIVE_W-1:0] left_d;
	logic signed [DRIVE_W-1:0] right_d;
	logic [HOLD_W-1:0]         hold_d;
	logic                      mode_d;

	function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [WIDE_W-1:0] v);
		logic signed [DRIVE_W-1:0] r;
		if (v > DRV_HI) begin
			r = DRV_HI[DRIVE_W-1:0];
		end else if (v < DRV_LO) begin
			r = DRV_LO[DRIVE_W-1:0];
		end else begin
			r = v[DRIVE_W-1:0];
		end
		return r;
	endfunction

	assign pop  = (state_q == ST_IDLE) && head.valid;
	assign load = (state_q == ST_DEC) && (!m_tvalid || m_tready);

	always_comb begin
		diff   = DIF_W'(rec_q.error_accum) - DIF_W'(prev_err_q);
		p_mult = PP_W'(rec_q.error_accum) * PP_W'($signed({1'b0, cfg.prop_gain_q8}));
		d_mult = DP_W'(diff) * DP_W'($signed({1'b0, cfg.deriv_gain_q8}));

		// divide by 256 toward zero: bias negatives before the shift
		p_adj  = p_prod_q + (p_prod_q[PP_W-1] ? PP_W'(255) : PP_W'(0));
		d_adj  = d_prod_q + (d_prod_q[DP_W-1] ? DP_W'(255) : DP_W'(0));
		pd_sum = SUM_W'($signed(p_adj[PP_W-1:8])) + SUM_W'($signed(d_adj[DP_W-1:8]));
		pd_mag = pd_sum[SUM_W-1] ? SUM_W'(-pd_sum) : SUM_W'(pd_sum);

		div_eff  = (cfg.scale_divisor == '0) ? 8'd1 : cfg.scale_divisor;
		trial    = {rem_q, dvd_q[MAG_W-1]};
		trial_ge = trial >= {1'b0, div_eff};

		steer       = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
		base_w      = $signed(WIDE_W'(cfg.base_speed));
		steer_left  = sat_drive(base_w - WIDE_W'(steer));
		steer_right = sat_drive(base_w + WIDE_W'(steer));
		base_drv    = $signed(DRIVE_W'(cfg.base_speed));

		act_d   = ACT_STEER;
		left_d  = '0;
		right_d = '0;
		hold_d  = '0;
		mode_d  = mode_q;
		if (!mode_q) begin
			if (rec_q.row_white > cfg.exit_white_count) begin
				mode_d = 1'b1;
				act_d  = ACT_MODE;
			end else if (rec_q.row_white > cfg.min_white_count) begin
				left_d  = steer_left;
				right_d = steer_right;
			end else begin
				act_d   = ACT_REVERSE;
				left_d  = DRV_LOST;
				right_d = DRV_LOST;
				hold_d  = HOLD_LOST;
			end
		end else begin
			if (rec_q.column_white > cfg.cross_count) begin
				if (rec_q.edge_white_flags == '0) begin
					left_d  = steer_left;
					right_d = steer_right;
				end else begin
					act_d   = ACT_STRAIGHT;
					left_d  = base_drv;
					right_d = base_drv;
				end
			end else if (rec_q.column_white != '0) begin
				act_d  = ACT_SPIN;
				hold_d = HOLD_SPIN;
				if (rec_q.upper_half_white >= cfg.cross_count) begin
					left_d  = -DRV_SPIN;
					right_d = DRV_SPIN;
				end else begin
					left_d  = DRV_SPIN;
					right_d = -DRV_SPIN;
				end
			end else begin
				act_d   = ACT_REVERSE;
				left_d  = DRV_BACK;
				right_d = DRV_BACK;
				hold_d  = HOLD_BACK;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head.rec;
		end
		if (state_q == ST_MUL) begin
			p_prod_q <= p_mult;
			d_prod_q <= d_mult;
		end
		if (state_q == ST_SUM) begin
			neg_q <= pd_sum[SUM_W-1];
			dvd_q <= pd_mag[MAG_W-1:0];
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? 8'(trial - {1'b0, div_eff}) : trial[7:0];
			dvd_q <= {dvd_q[MAG_W-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= 1'b0;
			prev_err_q    <= '0;
			div_cnt_q     <= '0;
			m_tvalid      <= 1'b0;
			action        <= ACT_STEER;
			left_drive    <= '0;
			right_drive   <= '0;
			hold_us       <= '0;
			crossing_mode <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one loads this cycle
			if (m_tready && !load) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					div_cnt_q <= CNT_W'(MAG_W);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == CNT_W'(1)) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (load) begin
						m_tvalid      <= 1'b1;
						action        <= act_d;
						left_drive    <= left_d;
						right_drive   <= right_d;
						hold_us       <= hold_d;
						crossing_mode <= mode_d;
						mode_q        <= mode_d;
						prev_err_q    <= rec_q.error_accum;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CLPD_ASSERT_NXT(a_mode_entry, load && (act_d == ACT_MODE), mode_q && crossing_mode)
	`CLPD_ASSERT_IMP(a_drive_range, m_tvalid, (left_drive != -DRIVE_W'(256)) && (right_drive != -DRIVE_W'(256)))
	`CLPD_ASSERT_IMP(a_div_count, state_q == ST_DIV, div_cnt_q != '0)
	`CLPD_ASSERT_IMP(a_pop_idle, pop, state_q == ST_IDLE)

endmodule

`default_nettype wire

### rtl/camera_line_follow_pd_steering_unit.sv
// Top level of the camera line-follow PD steering unit.
`default_nettype none

// Camera line-follow steering unit. Pixels of one image row (tuser low) and,
// in crossing mode, of the centre column (tuser high) stream in on the slave
// side at one pixel per clock while tready is high; tlast marks the last
// pixel of a frame. Each pixel is compared against the white threshold and
// folded into the frame statistics in the cycle it is accepted. On the last
// pixel a frame summary is pushed into a two-entry queue and the counts and
// error sum clear (edge flags carry over), so the next frame can follow
// straight on while the queue has room. The back end pops a summary, runs
// the Q8 PD law (multiply state for both products, then sum state), divides
// by the scale register with a restoring divider that resolves one quotient
// bit per cycle, decides the drive and loads the result register.
// The pixel stream only stalls (tready low) when two frame summaries are
// already waiting, which needs frames shorter than the back end latency or
// a result side that holds off.
// One result is given per frame on the master side: tuser carries the
// action, tdata the drives, hold time and mode after the frame. Write the
// configuration registers only while no frame is in flight.
module camera_line_follow_pd_steering_unit import clpd_pkg::*; #(
	parameter int ROW_WIDTH     = ROW_WIDTH_DEF,
	parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pixel stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,  // pixel_value[7:0], pixel_pos[16:8], zero pad
	input  wire logic                  s_tuser,  // is_column
	input  wire logic                  s_tlast,  // end_of_frame
	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,  // left_drive[8:0], right_drive[17:9],
	                                             // hold_us[35:18], crossing_mode[36], zero pad
	output logic [ACT_W-1:0]           m_tuser,  // action
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Register index map.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIV  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_WHITE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WHITE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS      = 3'd7;

	cfg_t     cfg_q;
	rec_req_t push;
	rec_req_t head;
	logic     q_full;
	logic     pop;

	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;
	logic [HOLD_W-1:0]         hold_us;
	logic                      crossing_mode;
	action_t                   action;

	// Hold the configuration; mask each write to the register width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_threshold  <= 8'd100;
			cfg_q.prop_gain_q8     <= 10'd51;
			cfg_q.deriv_gain_q8    <= 10'd51;
			cfg_q.base_speed       <= 8'd60;
			cfg_q.scale_divisor    <= 8'd40;
			cfg_q.exit_white_count <= 9'd250;
			cfg_q.min_white_count  <= 9'd5;
			cfg_q.cross_count      <= 8'd40;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:  cfg_q.pixel_threshold  <= cfg_data[7:0];
				REG_PROP_GAIN:  cfg_q.prop_gain_q8     <= cfg_data;
				REG_DERIV_GAIN: cfg_q.deriv_gain_q8    <= cfg_data;
				REG_BASE_SPEED: cfg_q.base_speed       <= cfg_data[7:0];
				REG_SCALE_DIV:  cfg_q.scale_divisor    <= cfg_data[7:0];
				REG_EXIT_WHITE: cfg_q.exit_white_count <= cfg_data[8:0];
				REG_MIN_WHITE:  cfg_q.min_white_count  <= cfg_data[8:0];
				REG_CROSS:      cfg_q.cross_count      <= cfg_data[7:0];
				default:        cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Front: accept pixel requests, push one summary per frame.
	clpd_front #(
		.ROW_WIDTH    (ROW_WIDTH),
		.COLUMN_HEIGHT(COLUMN_HEIGHT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.pixel_value    (s_tdata[7:0]),
		.pixel_pos      (s_tdata[16:8]),
		.is_column      (s_tuser),
		.end_of_frame   (s_tlast),
		.pixel_threshold(cfg_q.pixel_threshold),
		.q_full         (q_full),
		.push           (push)
	);

	// Queue: decouple the pixel stream from the per-frame arithmetic.
	clpd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	// Back: PD law, divide, decide, register the result request.
	clpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.left_drive   (left_drive),
		.right_drive  (right_drive),
		.hold_us      (hold_us),
		.crossing_mode(crossing_mode),
		.action       (action)
	);

	assign m_tdata = {3'b000, crossing_mode, hold_us, right_drive, left_drive};
	assign m_tuser = action;

endmodule

`default_nettype wire

### sim/tb_camera_line_follow_pd_steering_unit.sv
// Self-checking testbench of the camera line-follow PD steering unit.
`default_nettype none

module tb_camera_line_follow_pd_steering_unit;
	import clpd_pkg::*;

	localparam int ROW_W          = ROW_WIDTH_DEF;
	localparam int COL_H          = COLUMN_HEIGHT_DEF;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_LIMIT    = 2000;
	localparam int SETTLE_CYCLES  = 40;   // lets the back end settle after the last result
	localparam int HOLD_OFF       = 300;  // long receiver stall, in cycles
	localparam int ITEMS_PER_PHASE = 20;
	localparam int NUM_PHASES     = 9;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIV  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_WHITE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WHITE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS_CNT  = 3'd7;

	// Error sum bounds, drive limit, and fixed drives and holds of non-steering actions.
	localparam int ERR_HI     = 16383;
	localparam int ERR_LO     = -16384;
	localparam int DRIVE_LIM  = 255;
	localparam int LOST_DRIVE = -60;
	localparam int LOST_HOLD  = 200000;
	localparam int SPIN_DRIVE = 70;
	localparam int SPIN_HOLD  = 250000;
	localparam int BACK_DRIVE = -50;
	localparam int BACK_HOLD  = 100000;

	typedef struct {
		action_t                   action;
		logic signed [DRIVE_W-1:0] left;
		logic signed [DRIVE_W-1:0] right;
		logic [HOLD_W-1:0]         hold;
		logic                      crossing;
	} drive_cmd_t;

	// Frame statistics, PD law and drive decision, plus the queue of drive commands
	// still owed by the block.
	class steering_scoreboard;
		int threshold, prop_gain, deriv_gain, base_speed, scale_div;
		int exit_white, min_white, cross_cnt;
		bit crossing;
		int prev_err, err_acc, row_white, col_white, upper_white;
		bit [1:0] edges;
		drive_cmd_t pending_cmds[$];
		int errors, pixels, results;
		int act_seen[5];

		function new();
			threshold = 100; prop_gain = 51; deriv_gain = 51; base_speed = 60;
			scale_div = 40; exit_white = 250; min_white = 5; cross_cnt = 40;
			crossing = 0; prev_err = 0; err_acc = 0;
			row_white = 0; col_white = 0; upper_white = 0; edges = 2'b00;
			errors = 0; pixels = 0; results = 0;
			foreach (act_seen[i]) act_seen[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_THRESHOLD:  threshold  = int'(data[7:0]);
				REG_PROP_GAIN:  prop_gain  = int'(data[9:0]);
				REG_DERIV_GAIN: deriv_gain = int'(data[9:0]);
				REG_BASE_SPEED: base_speed = int'(data[7:0]);
				REG_SCALE_DIV:  scale_div  = int'(data[7:0]);
				REG_EXIT_WHITE: exit_white = int'(data[8:0]);
				REG_MIN_WHITE:  min_white  = int'(data[8:0]);
				REG_CROSS_CNT:  cross_cnt  = int'(data[7:0]);
				default: ;
			endcase
		endfunction

		function int clip(int v, int lo, int hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// Integer division truncates toward zero, as the Q8 law requires.
		function int q8_scale(int x, int gain);
			return (x * gain) / 256;
		endfunction

		function int outstanding();
			return pending_cmds.size();
		endfunction

		function void note_pixel(logic [PIX_W-1:0] val, logic [POS_W-1:0] pos,
		                         logic is_col, logic eof);
			bit white;
			int p, d, s, lft, rgt;
			drive_cmd_t cmd;
			pixels++;
			white = (int'(val) >= threshold);
			if (is_col) begin
				if (int'(pos) < COL_H && white && col_white < 255) col_white++;
			end else if (int'(pos) < ROW_W) begin
				if (pos == 0) edges[0] = white;
				if (int'(pos) == ROW_W - 1) edges[1] = white;
				if (white) begin
					if (row_white < 511) row_white++;
					if (int'(pos) >= ROW_W / 2 && upper_white < 255) upper_white++;
					err_acc = clip(err_acc + int'(pos) - ROW_W / 2, ERR_LO, ERR_HI);
				end
			end
			if (!eof) return;

			p = q8_scale(err_acc, prop_gain);
			d = q8_scale(err_acc - prev_err, deriv_gain);
			s = (p + d) / ((scale_div == 0) ? 1 : scale_div);
			prev_err = err_acc;
			lft = 0;
			rgt = 0;
			cmd.action = ACT_STEER;
			cmd.hold = '0;

			if (!crossing) begin
				if (row_white > exit_white) begin
					crossing = 1;
					cmd.action = ACT_MODE;
				end else if (row_white > min_white) begin
					lft = base_speed - s;
					rgt = base_speed + s;
				end else begin
					cmd.action = ACT_REVERSE;
					lft = LOST_DRIVE;
					rgt = LOST_DRIVE;
					cmd.hold = HOLD_W'(LOST_HOLD);
				end
			end else begin
				if (col_white > cross_cnt) begin
					if (edges == 2'b00) begin
						lft = base_speed - s;
						rgt = base_speed + s;
					end else begin
						cmd.action = ACT_STRAIGHT;
						lft = base_speed;
						rgt = base_speed;
					end
				end else if (col_white > 0) begin
					cmd.action = ACT_SPIN;
					cmd.hold = HOLD_W'(SPIN_HOLD);
					lft = (upper_white >= cross_cnt) ? -SPIN_DRIVE : SPIN_DRIVE;
					rgt = -lft;
				end else begin
					cmd.action = ACT_REVERSE;
					lft = BACK_DRIVE;
					rgt = BACK_DRIVE;
					cmd.hold = HOLD_W'(BACK_HOLD);
				end
			end

			cmd.left = DRIVE_W'(clip(lft, -DRIVE_LIM, DRIVE_LIM));
			cmd.right = DRIVE_W'(clip(rgt, -DRIVE_LIM, DRIVE_LIM));
			cmd.crossing = crossing;
			pending_cmds.push_back(cmd);
			act_seen[cmd.action]++;

			err_acc = 0;
			row_white = 0;
			col_white = 0;
			upper_white = 0;
		endfunction

		function void check_result(logic [ACT_W-1:0] act, logic signed [DRIVE_W-1:0] lft,
		                           logic signed [DRIVE_W-1:0] rgt, logic [HOLD_W-1:0] hold,
		                           logic mode);
			drive_cmd_t want;
			results++;
			if (pending_cmds.size() == 0) begin
				errors++;
				$display("%0t: result with no frame outstanding: action %0d left %0d right %0d",
				         $time, act, lft, rgt);
				return;
			end
			want = pending_cmds.pop_front();
			if (act !== want.action) begin
				errors++;
				$display("%0t: action: expected %0d, actual %0d", $time, want.action, act);
			end
			if (lft !== want.left) begin
				errors++;
				$display("%0t: left_drive: expected %0d, actual %0d", $time, want.left, lft);
			end
			if (rgt !== want.right) begin
				errors++;
				$display("%0t: right_drive: expected %0d, actual %0d", $time, want.right, rgt);
			end
			if (hold !== want.hold) begin
				errors++;
				$display("%0t: hold_us: expected %0d, actual %0d", $time, want.hold, hold);
			end
			if (mode !== want.crossing) begin
				errors++;
				$display("%0t: crossing_mode: expected %0d, actual %0d", $time,
				         want.crossing, mode);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [ACT_W-1:0]      m_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	steering_scoreboard sb;
	int  cycles = 0;
	int  items_sent = 0;
	bit  sender_idle = 1;
	bit  receiver_idle = 1;
	bit  hold_req = 0;
	int  col_pct = 30;

	camera_line_follow_pd_steering_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Write one register at a negative edge, drop the enable at the next negative edge.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(data);
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, CFG_DATA_W'(data));
	endtask

	// Offer one pixel request (after a random gap if sender_idle); return on accept.
	// Valid stays high after acceptance so back-to-back requests need no drop.
	task automatic send_pixel(logic [PIX_W-1:0] val, logic [POS_W-1:0] pos,
	                          logic is_col, logic eof);
		int gap;
		gap = sender_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {{(S_TDATA_W - PIX_W - POS_W){1'b0}}, pos, val};
		s_tuser = is_col;
		s_tlast = eof;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(val, pos, is_col, eof);
		items_sent++;
	endtask

	// Random frame: mixes in-range, edge and out-of-range positions on both the
	// row and the centre column, with extreme intensities favored.
	task automatic send_frame(int len);
		logic [PIX_W-1:0] val;
		logic [POS_W-1:0] pos;
		logic             is_col;
		int               r;
		for (int i = 0; i < len; i++) begin
			is_col = ($urandom_range(0, 99) < col_pct);
			r = $urandom_range(0, 99);
			if (r < 12)
				pos = POS_W'(is_col ? $urandom_range(COL_H, 511) : $urandom_range(ROW_W, 511));
			else if (r < 30)
				pos = POS_W'($urandom_range(0, 1) ? 0 : (is_col ? COL_H - 1 : ROW_W - 1));
			else
				pos = POS_W'(is_col ? $urandom_range(0, COL_H - 1) : $urandom_range(0, ROW_W - 1));
			r = $urandom_range(0, 99);
			val = (r < 10) ? 8'd0 : ((r < 20) ? 8'd255 : 8'($urandom_range(0, 255)));
			send_pixel(val, pos, is_col, i == len - 1);
		end
	endtask

	// Long all-white frame that drives the frame counters and the error sum into
	// saturation. Column pixels go on odd slots until n_col of them are sent.
	task automatic send_long_frame(int n_row, int row_lo, int row_hi, int n_col);
		int cols_sent;
		int total;
		bit is_col;
		cols_sent = 0;
		total = n_row + n_col;
		for (int i = 0; i < total; i++) begin
			is_col = (i % 2 == 1) && (cols_sent < n_col);
			if (is_col) begin
				cols_sent++;
				send_pixel(8'd255, POS_W'($urandom_range(0, COL_H - 1)), 1'b1,
				           i == total - 1);
			end else begin
				send_pixel(8'd255, POS_W'($urandom_range(row_lo, row_hi)), 1'b0,
				           i == total - 1);
			end
		end
	endtask

	// Drop valid, wait for every owed result, then let the back end settle.
	task automatic drain_results();
		int waited;
		waited = 0;
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		while (sb.outstanding() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register settings and idling per phase. Phases 1 to 3 stay in line-follow
	// mode (exit count at its ceiling), phase 4 forces the switch, 5 to 8 cross.
	task automatic configure_phase(int ph);
		case (ph)
			1: begin
				sender_idle = 0; receiver_idle = 0;
				write_reg(REG_THRESHOLD, 0);
				write_reg(REG_PROP_GAIN, 1023);
				write_reg(REG_DERIV_GAIN, 1023);
				write_reg(REG_BASE_SPEED, 255);
				write_reg(REG_SCALE_DIV, 0);         // zero divisor acts as one
				write_reg(REG_EXIT_WHITE, 511);
				write_reg(REG_MIN_WHITE, 0);
				write_reg(REG_CROSS_CNT, 0);
			end
			2: begin
				sender_idle = 1; receiver_idle = 0;
				write_reg(REG_THRESHOLD, 'h3FF);     // upper bits masked off
				write_reg(REG_PROP_GAIN, 0);
				write_reg(REG_DERIV_GAIN, 0);
				write_reg(REG_BASE_SPEED, 0);
				write_reg(REG_SCALE_DIV, 255);
				write_reg(REG_EXIT_WHITE, 'h3FF);
				write_reg(REG_MIN_WHITE, 511);
				write_reg(REG_CROSS_CNT, 255);
			end
			3: begin
				sender_idle = 0; receiver_idle = 1;
				write_reg(REG_THRESHOLD, $urandom_range(40, 200));
				write_reg(REG_PROP_GAIN, $urandom_range(0, 1023));
				write_reg(REG_DERIV_GAIN, $urandom_range(0, 1023));
				write_reg(REG_BASE_SPEED, $urandom_range(0, 255));
				write_reg(REG_SCALE_DIV, $urandom_range(1, 255));
				write_reg(REG_EXIT_WHITE, 511);
				write_reg(REG_MIN_WHITE, $urandom_range(0, 12));
				write_reg(REG_CROSS_CNT, $urandom_range(0, 255));
			end
			4: begin
				sender_idle = 1; receiver_idle = 1;
				write_reg(REG_THRESHOLD, $urandom_range(0, 60));
				write_reg(REG_PROP_GAIN, $urandom_range(0, 1023));
				write_reg(REG_DERIV_GAIN, $urandom_range(0, 1023));
				write_reg(REG_BASE_SPEED, $urandom_range(0, 255));
				write_reg(REG_SCALE_DIV, $urandom_range(0, 255));
				write_reg(REG_EXIT_WHITE, $urandom_range(0, 6));
				write_reg(REG_MIN_WHITE, $urandom_range(0, 6));
				write_reg(REG_CROSS_CNT, $urandom_range(0, 8));
			end
			5: begin
				write_reg(REG_THRESHOLD, $urandom_range(40, 160));
				write_reg(REG_CROSS_CNT, 0);
				write_reg(REG_SCALE_DIV, $urandom_range(1, 60));
			end
			6: begin
				sender_idle = 0; receiver_idle = 0;
				write_reg(REG_THRESHOLD, $urandom_range(20, 120));
				write_reg(REG_CROSS_CNT, 'h3FF);     // masks to 255
			end
			7: begin
				sender_idle = 1; receiver_idle = 1;
				write_reg(REG_THRESHOLD, $urandom_range(60, 200));
				write_reg(REG_PROP_GAIN, 1023);
				write_reg(REG_DERIV_GAIN, 1023);
				write_reg(REG_BASE_SPEED, 255);
				write_reg(REG_SCALE_DIV, 1);
				write_reg(REG_CROSS_CNT, $urandom_range(1, 10));
			end
			8: begin
				write_reg(REG_THRESHOLD, $urandom_range(0, 255));
				write_reg(REG_PROP_GAIN, $urandom_range(0, 1023));
				write_reg(REG_DERIV_GAIN, $urandom_range(0, 1023));
				write_reg(REG_BASE_SPEED, 0);
				write_reg(REG_SCALE_DIV, $urandom_range(0, 255));
				write_reg(REG_EXIT_WHITE, $urandom_range(0, 511));
				write_reg(REG_MIN_WHITE, $urandom_range(0, 511));
				write_reg(REG_CROSS_CNT, $urandom_range(0, 6));
			end
			default: ;
		endcase
	endtask

	// Result side: with receiver_idle, stall a random number of cycles per result, or
	// hold off for a long stretch once asked to, then accept on the next valid edge.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_idle ? $urandom_range(0, 9) : 0;
			if (hold_req) begin
				hold_req = 0;
				stall = HOLD_OFF;
			end
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tuser, m_tdata[8:0], m_tdata[17:9], m_tdata[35:18], m_tdata[36]);
		end
	end

	initial begin
		int start;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames at reset settings.
		// Threshold boundary, both edges, ignored row and column positions, end of
		// frame on an ignored pixel: two white row pixels, so the line counts as lost.
		send_pixel(8'd0,   9'd0,   1'b0, 1'b0);
		send_pixel(8'd255, 9'd319, 1'b0, 1'b0);
		send_pixel(8'd99,  9'd200, 1'b0, 1'b0);
		send_pixel(8'd100, 9'd159, 1'b0, 1'b0);
		send_pixel(8'd255, 9'd239, 1'b1, 1'b0);
		send_pixel(8'd255, 9'd240, 1'b1, 1'b0);
		send_pixel(8'd255, 9'd511, 1'b1, 1'b0);
		send_pixel(8'd255, 9'd320, 1'b0, 1'b1);
		// Seven white pixels: steer.
		send_pixel(8'd255, 9'd0,   1'b0, 1'b0);
		send_pixel(8'd200, 9'd319, 1'b0, 1'b0);
		send_pixel(8'd180, 9'd160, 1'b0, 1'b0);
		send_pixel(8'd150, 9'd1,   1'b0, 1'b0);
		send_pixel(8'd128, 9'd300, 1'b0, 1'b0);
		send_pixel(8'd101, 9'd170, 1'b0, 1'b0);
		send_pixel(8'd100, 9'd256, 1'b0, 1'b1);
		// Empty frame right after: pure derivative, then reverse.
		send_pixel(8'hAA, 9'h155, 1'b0, 1'b1);
		drain_results();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			configure_phase(ph);
			start = items_sent;
			case (ph)
				// Row count, upper half and error sum saturate high.
				1: send_long_frame(520, ROW_W - 1, ROW_W - 1, 0);
				3: begin
					// Error sum saturates low.
					send_long_frame(110, 0, 0, 0);
					// Hold off the result side while short frames keep streaming, so
					// the summary queue fills and the pixel input stalls.
					hold_req = 1;
					for (int f = 0; f < 30; f++) send_frame($urandom_range(1, 3));
				end
				// Column and upper-half counts saturate in crossing mode.
				6: send_long_frame(260, ROW_W / 2, ROW_W - 1, 260);
				default: ;
			endcase
			while (items_sent - start < ITEMS_PER_PHASE) send_frame($urandom_range(1, 16));
			drain_results();
		end

		if (sb.outstanding() > 0) begin
			sb.errors += sb.outstanding();
			$display("%0t: %0d expected results never arrived", $time, sb.outstanding());
		end
		$display("Covered %0d pixels and %0d results across %0d register settings.",
		         sb.pixels, sb.results, NUM_PHASES);
		$display("Actions: steer %0d, straight %0d, reverse %0d, spin %0d, mode change %0d.",
		         sb.act_seen[ACT_STEER], sb.act_seen[ACT_STRAIGHT], sb.act_seen[ACT_REVERSE],
		         sb.act_seen[ACT_SPIN], sb.act_seen[ACT_MODE]);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
